FILE: src/i2ct_pkg.sv
// i2ct_pkg: shared codes and types for the i2c target bit engine
// no dependencies; used by the engine, the register block and the top level
`default_nettype none

package i2ct_pkg;

    // command codes carried by the request
    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_RX    = 3'd1;
    localparam logic [2:0] CMD_TX    = 3'd2;
    localparam logic [2:0] CMD_ACK   = 3'd3;
    localparam logic [2:0] CMD_COND  = 3'd4;
    localparam logic [2:0] CMD_PULSE = 3'd5;

    // active primitive, same encoding as the command that started it
    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_RX    = 3'd1;
    localparam logic [2:0] MODE_TX    = 3'd2;
    localparam logic [2:0] MODE_ACK   = 3'd3;
    localparam logic [2:0] MODE_COND  = 3'd4;
    localparam logic [2:0] MODE_PULSE = 3'd5;

    // event codes reported with each result
    localparam logic [2:0] EV_NONE  = 3'd0;
    localparam logic [2:0] EV_OCTET = 3'd1;
    localparam logic [2:0] EV_START = 3'd2;
    localparam logic [2:0] EV_STOP  = 3'd3;
    localparam logic [2:0] EV_SENT  = 3'd4;
    localparam logic [2:0] EV_PULSE = 3'd5;

    // configuration register indexes
    localparam logic REG_OWN_ADDRESS = 1'b0;

    localparam int unsigned ADDR_W = 7;

    // one input request
    typedef struct packed {
        logic [2:0] cmd;
        logic       scl_level;
        logic       sda_level;
        logic [7:0] tx_byte;
        logic       allow_start;
    } t_item;

    // one result
    typedef struct packed {
        logic       sda_drive;
        logic       done_res;
        logic [2:0] event_kind;
        logic [7:0] rx_octet;
        logic       address_hit;
        logic       read_request;
        logic       busy_res;
    } t_result;

endpackage

`default_nettype wire

FILE: src/i2ct_regs.sv
// i2ct_regs: apb-style configuration register holding the own bus address
// depends on i2ct_pkg for the register index and address width
`default_nettype none

module i2ct_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [2:0]                 paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output logic [i2ct_pkg::ADDR_W-1:0]     o_own_address
);

    logic [i2ct_pkg::ADDR_W-1:0] r_own_address;
    logic                        w_sel_own;

    assign w_sel_own = (paddr[2] == i2ct_pkg::REG_OWN_ADDRESS);
    assign pready    = 1'b1;

    // register write at the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address <= '0;
        end else if (psel && penable && pwrite && w_sel_own) begin
            r_own_address <= pwdata[i2ct_pkg::ADDR_W-1:0];
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        if (w_sel_own) begin
            prdata[i2ct_pkg::ADDR_W-1:0] = r_own_address;
        end
    end

    assign o_own_address = r_own_address;

endmodule

`default_nettype wire

FILE: src/i2ct_engine.sv
// i2ct_engine: primitive state and the per-request next-state and result logic
// depends on i2ct_pkg for codes and the request and result structs
`default_nettype none

module i2ct_engine (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_step,
    input  wire i2ct_pkg::t_item            i_item,
    input  wire logic [i2ct_pkg::ADDR_W-1:0] i_own_address,
    output i2ct_pkg::t_result               o_result
);

    logic [2:0] r_mode,  n_mode;
    logic       r_phase, n_phase;
    logic [3:0] r_bits,  n_bits;
    logic [7:0] r_shift, n_shift;
    logic       r_held,  n_held;
    logic       r_drive, n_drive;
    logic       r_start, n_start;

    logic       w_done;
    logic [2:0] w_ev;
    logic [7:0] w_oct;
    logic [3:0] w_bits_inc;
    logic       w_pulse_end;

    assign w_bits_inc = r_bits + 4'd1;

    // end of a clock pulse for the pulse-counting primitives
    assign w_pulse_end = r_phase && !i_item.scl_level;

    // next state and event for one request
    always_comb begin
        n_mode  = r_mode;
        n_phase = r_phase;
        n_bits  = r_bits;
        n_shift = r_shift;
        n_held  = r_held;
        n_drive = r_drive;
        n_start = r_start;
        w_done  = 1'b0;
        w_ev    = i2ct_pkg::EV_NONE;
        w_oct   = '0;

        if (i_item.cmd != i2ct_pkg::CMD_TICK) begin
            // start a primitive only when idle and the code is known
            if (r_mode == i2ct_pkg::MODE_IDLE && i_item.cmd <= i2ct_pkg::CMD_PULSE) begin
                n_mode  = i_item.cmd;
                n_phase = 1'b0;
                n_bits  = '0;
                n_shift = '0;
                case (i_item.cmd)
                    i2ct_pkg::CMD_TX: begin
                        n_drive = i_item.tx_byte[7];
                        n_shift = {i_item.tx_byte[6:0], 1'b0};
                    end
                    i2ct_pkg::CMD_ACK: begin
                        n_drive = 1'b0;
                    end
                    i2ct_pkg::CMD_COND: begin
                        n_start = i_item.allow_start;
                    end
                    default: begin
                    end
                endcase
            end
        end else begin
            case (r_mode)
                i2ct_pkg::MODE_RX: begin
                    if (!r_phase) begin
                        // first high sample of the pulse takes the bit
                        if (i_item.scl_level) begin
                            n_phase = 1'b1;
                            n_held  = i_item.sda_level;
                            n_shift = {r_shift[6:0], i_item.sda_level};
                            n_bits  = w_bits_inc;
                        end
                    end else if (i_item.scl_level) begin
                        // sda moving while scl high is a bus condition
                        if (!r_held && i_item.sda_level) begin
                            w_done = 1'b1;
                            w_ev   = i2ct_pkg::EV_STOP;
                        end else if (r_held && !i_item.sda_level) begin
                            w_done = 1'b1;
                            w_ev   = i2ct_pkg::EV_START;
                        end
                    end else begin
                        n_phase = 1'b0;
                        if (r_bits[3]) begin
                            w_done = 1'b1;
                            w_ev   = i2ct_pkg::EV_OCTET;
                            w_oct  = r_shift;
                        end
                    end
                end
                i2ct_pkg::MODE_TX: begin
                    if (!r_phase) begin
                        n_phase = i_item.scl_level;
                    end else if (w_pulse_end) begin
                        n_phase = 1'b0;
                        n_bits  = w_bits_inc;
                        if (w_bits_inc[3]) begin
                            n_drive = 1'b1;
                            w_done  = 1'b1;
                            w_ev    = i2ct_pkg::EV_SENT;
                        end else begin
                            n_drive = r_shift[7];
                            n_shift = {r_shift[6:0], 1'b0};
                        end
                    end
                end
                i2ct_pkg::MODE_ACK: begin
                    if (!r_phase) begin
                        n_phase = i_item.scl_level;
                    end else if (w_pulse_end) begin
                        n_phase = 1'b0;
                        n_drive = 1'b1;
                        w_done  = 1'b1;
                        w_ev    = i2ct_pkg::EV_PULSE;
                    end
                end
                i2ct_pkg::MODE_PULSE: begin
                    if (!r_phase) begin
                        n_phase = i_item.scl_level;
                    end else if (w_pulse_end) begin
                        n_phase = 1'b0;
                        w_done  = 1'b1;
                        w_ev    = i2ct_pkg::EV_PULSE;
                    end
                end
                i2ct_pkg::MODE_COND: begin
                    if (!i_item.scl_level) begin
                        n_phase = 1'b0;
                        n_held  = i_item.sda_level;
                    end else begin
                        n_phase = 1'b1;
                        if (!r_held && i_item.sda_level) begin
                            w_done = 1'b1;
                            w_ev   = i2ct_pkg::EV_STOP;
                        end else if (r_start && r_held && !i_item.sda_level) begin
                            w_done = 1'b1;
                            w_ev   = i2ct_pkg::EV_START;
                        end
                    end
                end
                default: begin
                    // idle: track sda for a later condition wait
                    n_held = i_item.sda_level;
                end
            endcase
            if (w_done) begin
                n_mode  = i2ct_pkg::MODE_IDLE;
                n_phase = 1'b0;
            end
        end
    end

    // primitive state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= i2ct_pkg::MODE_IDLE;
            r_phase <= 1'b0;
            r_bits  <= '0;
            r_shift <= '0;
            r_held  <= 1'b1;
            r_drive <= 1'b1;
            r_start <= 1'b0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_phase <= n_phase;
            r_bits  <= n_bits;
            r_shift <= n_shift;
            r_held  <= n_held;
            r_drive <= n_drive;
            r_start <= n_start;
        end
    end

    // result of this request
    always_comb begin
        o_result              = '0;
        o_result.sda_drive    = n_drive;
        o_result.done_res     = w_done;
        o_result.event_kind   = w_ev;
        o_result.rx_octet     = w_oct;
        o_result.busy_res     = (n_mode != i2ct_pkg::MODE_IDLE);
        if (w_ev == i2ct_pkg::EV_OCTET) begin
            o_result.address_hit  = (w_oct[7:1] == i_own_address);
            o_result.read_request = w_oct[0];
        end
    end

endmodule

`default_nettype wire

FILE: src/i2c_target_bit_engine.sv
// i2c_target_bit_engine: request register, engine and result register
// depends on i2ct_pkg, i2ct_regs and i2ct_engine
//
// Usage:
//   Requests enter on i_valid/o_ready with i_cmd and its operands. A line
//   sample tick (cmd 0) carries the sampled scl and sda levels and advances
//   the active primitive; codes 1 to 5 start a primitive when idle;
//   other commands are ignored. Every request gives exactly one result on
//   o_valid/i_ready carrying the sda drive level, done flag, event and,
//   for a received octet, the byte, address match and read flag.
// Throughput:
//   a request passes the request register, then the engine logic and the
//   result register; one request per cycle is sustained while i_ready is
//   high, set by the single pass of the engine logic between the two.
// Stall:
//   when i_ready is low the result register holds, the request register
//   fills and o_ready drops after one more request; no result is lost.
// Reset:
//   i_rst_n is synchronous; both registers empty, engine idle with sda
//   released, own address zero. Write own_address at byte 0 of the apb
//   port only while no request is outstanding.
`default_nettype none

module i2c_target_bit_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_cmd,
    input  wire logic        i_scl_level,
    input  wire logic        i_sda_level,
    input  wire logic [7:0]  i_tx_byte,
    input  wire logic        i_allow_start,
    // result channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_sda_drive,
    output logic             o_done_res,
    output logic [2:0]       o_event_kind,
    output logic [7:0]       o_rx_octet,
    output logic             o_address_hit,
    output logic             o_read_request,
    output logic             o_busy_res,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic                         r_in_valid;
    i2ct_pkg::t_item              r_in;
    logic                         r_out_valid;
    i2ct_pkg::t_result            r_out;
    i2ct_pkg::t_result            w_result;
    logic [i2ct_pkg::ADDR_W-1:0]  w_own_address;
    logic                         w_move;

    i2ct_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_own_address (w_own_address)
    );

    // request moves into the result register when that one is free
    assign w_move  = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_move;

    // request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in.cmd         <= i_cmd;
            r_in.scl_level   <= i_scl_level;
            r_in.sda_level   <= i_sda_level;
            r_in.tx_byte     <= i_tx_byte;
            r_in.allow_start <= i_allow_start;
        end
    end

    i2ct_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_move),
        .i_item        (r_in),
        .i_own_address (w_own_address),
        .o_result      (w_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out <= w_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sda_drive    = r_out.sda_drive;
    assign o_done_res     = r_out.done_res;
    assign o_event_kind   = r_out.event_kind;
    assign o_rx_octet     = r_out.rx_octet;
    assign o_address_hit  = r_out.address_hit;
    assign o_read_request = r_out.read_request;
    assign o_busy_res     = r_out.busy_res;

endmodule

`default_nettype wire

FILE: src/i2ct_checker.sv
// i2ct_checker: port-level assertions on the i2c target bit engine
// depends on i2ct_pkg for event codes; bound to the top level below
`default_nettype none

module i2ct_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic       o_sda_drive,
    input wire logic       o_done_res,
    input wire logic [2:0] o_event_kind,
    input wire logic [7:0] o_rx_octet,
    input wire logic       o_address_hit,
    input wire logic       o_read_request,
    input wire logic       o_busy_res,
    input wire logic       pready
);

    // a finished primitive always names its event and leaves the engine idle
    a_done_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_done_res == (o_event_kind != i2ct_pkg::EV_NONE))
                    && (!o_done_res || !o_busy_res))
        else $error("done flag, event and busy disagree");

    // octet fields are zero unless an octet was received
    a_octet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_kind != i2ct_pkg::EV_OCTET)
            |-> (o_rx_octet == 8'd0 && !o_address_hit && !o_read_request))
        else $error("octet fields set without an octet event");

    // sda is released when a byte has been sent or received
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_event_kind == i2ct_pkg::EV_SENT
                     || o_event_kind == i2ct_pkg::EV_OCTET)) |-> o_sda_drive)
        else $error("sda still driven after byte end");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_event_kind)
                                   && $stable(o_rx_octet) && $stable(o_sda_drive)))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind i2c_target_bit_engine i2ct_checker u_i2ct_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_sda_drive    (o_sda_drive),
    .o_done_res     (o_done_res),
    .o_event_kind   (o_event_kind),
    .o_rx_octet     (o_rx_octet),
    .o_address_hit  (o_address_hit),
    .o_read_request (o_read_request),
    .o_busy_res     (o_busy_res),
    .pready         (pready)
);

`default_nettype wire

FILE: tb/tb.sv
// tb: self-checking bench for i2c_target_bit_engine, drives requests, configuration and stalls
// depends on i2ct_pkg and the i2c_target_bit_engine top level
`timescale 1ns / 1ps

// tracks engine state, works out the result of each request and checks the results
class line_event_model;
    logic [6:0]          own_address;
    logic [2:0]          mode;
    bit                  phase_high;
    logic [3:0]          bit_count;
    logic [7:0]          shifter;
    bit                  held_sda;
    bit                  sda_out;
    bit                  start_ok;
    i2ct_pkg::t_result   due_results[$];
    int                  bad_results;

    function new();
        own_address = '0;
        mode        = i2ct_pkg::MODE_IDLE;
        phase_high  = 1'b0;
        bit_count   = '0;
        shifter     = '0;
        held_sda    = 1'b1;
        sda_out     = 1'b1;
        start_ok    = 1'b0;
        bad_results = 0;
    endfunction

    function bit busy();
        return mode != i2ct_pkg::MODE_IDLE;
    endfunction

    // clock pulse of the pulse-counting primitives, 1 on the falling edge that ends it
    function bit pulse_ends(bit scl);
        if (!phase_high) begin
            phase_high = scl;
            return 1'b0;
        end
        if (!scl) begin
            phase_high = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function string show(i2ct_pkg::t_result r);
        return $sformatf("sda=%0b done=%0b event=%0d octet=%02h hit=%0b read=%0b busy=%0b",
                         r.sda_drive, r.done_res, r.event_kind, r.rx_octet,
                         r.address_hit, r.read_request, r.busy_res);
    endfunction

    // accepted request: advance the engine copy, queue the result, 1 if it engaged the engine
    function bit take_request(i2ct_pkg::t_item it);
        i2ct_pkg::t_result r;
        bit                engaged;
        r       = '0;
        engaged = 1'b0;
        if (it.cmd != i2ct_pkg::CMD_TICK) begin
            // a command only starts a primitive from idle
            if (mode == i2ct_pkg::MODE_IDLE && it.cmd <= i2ct_pkg::CMD_PULSE) begin
                engaged    = 1'b1;
                mode       = it.cmd;
                phase_high = 1'b0;
                bit_count  = '0;
                shifter    = '0;
                case (it.cmd)
                    i2ct_pkg::CMD_TX: begin
                        sda_out = it.tx_byte[7];
                        shifter = {it.tx_byte[6:0], 1'b0};
                    end
                    i2ct_pkg::CMD_ACK: sda_out = 1'b0;
                    i2ct_pkg::CMD_COND: start_ok = it.allow_start;
                    default: ;
                endcase
            end
        end else begin
            engaged = (mode != i2ct_pkg::MODE_IDLE);
            case (mode)
                i2ct_pkg::MODE_RX: begin
                    if (!phase_high) begin
                        // first high sample of a pulse takes the bit
                        if (it.scl_level) begin
                            phase_high = 1'b1;
                            held_sda   = it.sda_level;
                            shifter    = {shifter[6:0], it.sda_level};
                            bit_count  = bit_count + 4'd1;
                        end
                    end else if (it.scl_level) begin
                        // data moving while clock high is a bus condition
                        if (!held_sda && it.sda_level) begin
                            r.done_res   = 1'b1;
                            r.event_kind = i2ct_pkg::EV_STOP;
                        end else if (held_sda && !it.sda_level) begin
                            r.done_res   = 1'b1;
                            r.event_kind = i2ct_pkg::EV_START;
                        end
                    end else begin
                        phase_high = 1'b0;
                        if (bit_count >= 4'd8) begin
                            r.done_res     = 1'b1;
                            r.event_kind   = i2ct_pkg::EV_OCTET;
                            r.rx_octet     = shifter;
                            r.address_hit  = (shifter[7:1] == own_address);
                            r.read_request = shifter[0];
                        end
                    end
                end
                i2ct_pkg::MODE_TX: begin
                    if (pulse_ends(it.scl_level)) begin
                        bit_count = bit_count + 4'd1;
                        if (bit_count >= 4'd8) begin
                            sda_out      = 1'b1;
                            r.done_res   = 1'b1;
                            r.event_kind = i2ct_pkg::EV_SENT;
                        end else begin
                            sda_out = shifter[7];
                            shifter = {shifter[6:0], 1'b0};
                        end
                    end
                end
                i2ct_pkg::MODE_ACK: begin
                    if (pulse_ends(it.scl_level)) begin
                        sda_out      = 1'b1;
                        r.done_res   = 1'b1;
                        r.event_kind = i2ct_pkg::EV_PULSE;
                    end
                end
                i2ct_pkg::MODE_PULSE: begin
                    if (pulse_ends(it.scl_level)) begin
                        r.done_res   = 1'b1;
                        r.event_kind = i2ct_pkg::EV_PULSE;
                    end
                end
                i2ct_pkg::MODE_COND: begin
                    // low samples hold sda, high samples compare against it
                    if (!it.scl_level) begin
                        phase_high = 1'b0;
                        held_sda   = it.sda_level;
                    end else begin
                        phase_high = 1'b1;
                        if (!held_sda && it.sda_level) begin
                            r.done_res   = 1'b1;
                            r.event_kind = i2ct_pkg::EV_STOP;
                        end else if (start_ok && held_sda && !it.sda_level) begin
                            r.done_res   = 1'b1;
                            r.event_kind = i2ct_pkg::EV_START;
                        end
                    end
                end
                default: held_sda = it.sda_level;
            endcase
            if (r.done_res) begin
                mode       = i2ct_pkg::MODE_IDLE;
                phase_high = 1'b0;
            end
        end
        r.sda_drive = sda_out;
        r.busy_res  = (mode != i2ct_pkg::MODE_IDLE);
        due_results.push_back(r);
        return engaged;
    endfunction

    function void check_result(i2ct_pkg::t_result got);
        i2ct_pkg::t_result want;
        if (due_results.size() == 0) begin
            bad_results++;
            if (bad_results <= 10)
                $display("tb: result with nothing due: %s", show(got));
            return;
        end
        want = due_results.pop_front();
        if (got.sda_drive !== want.sda_drive || got.done_res !== want.done_res ||
            got.event_kind !== want.event_kind || got.rx_octet !== want.rx_octet ||
            got.address_hit !== want.address_hit || got.read_request !== want.read_request ||
            got.busy_res !== want.busy_res) begin
            bad_results++;
            if (bad_results <= 10)
                $display("tb: mismatch\n  expected %s\n  actual   %s", show(want), show(got));
        end
    endfunction
endclass

module tb;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 160;

    // codes with no primitive behind them
    localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_cmd;
    logic        i_scl_level;
    logic        i_sda_level;
    logic [7:0]  i_tx_byte;
    logic        i_allow_start;
    logic        o_valid;
    logic        i_ready;
    logic        o_sda_drive;
    logic        o_done_res;
    logic [2:0]  o_event_kind;
    logic [7:0]  o_rx_octet;
    logic        o_address_hit;
    logic        o_read_request;
    logic        o_busy_res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    line_event_model sb;
    bit              steady;
    int              engine_items;
    int              cycle_count;

    i2c_target_bit_engine dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_scl_level    (i_scl_level),
        .i_sda_level    (i_sda_level),
        .i_tx_byte      (i_tx_byte),
        .i_allow_start  (i_allow_start),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sda_drive    (o_sda_drive),
        .o_done_res     (o_done_res),
        .o_event_kind   (o_event_kind),
        .o_rx_octet     (o_rx_octet),
        .o_address_hit  (o_address_hit),
        .o_read_request (o_read_request),
        .o_busy_res     (o_busy_res),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // result side: check accepted results, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(i2ct_pkg::t_result'({o_sda_drive, o_done_res, o_event_kind,
                                                 o_rx_octet, o_address_hit, o_read_request,
                                                 o_busy_res}));
        i_ready <= steady || ($urandom_range(99) >= 24);
    end

    // one request, held until taken
    task automatic send_request(logic [2:0] cmd, bit scl, bit sda, logic [7:0] txb, bit alw);
        i2ct_pkg::t_item it;
        it.cmd         = cmd;
        it.scl_level   = scl;
        it.sda_level   = sda;
        it.tx_byte     = txb;
        it.allow_start = alw;
        while (!steady && $urandom_range(99) < 24) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_cmd         <= cmd;
        i_scl_level   <= scl;
        i_sda_level   <= sda;
        i_tx_byte     <= txb;
        i_allow_start <= alw;
        do @(posedge i_clk); while (!o_ready);
        if (sb.take_request(it))
            engine_items++;
    endtask

    task automatic line_tick(bit scl, bit sda);
        send_request(i2ct_pkg::CMD_TICK, scl, sda, 8'($urandom_range(255)),
                     1'($urandom_range(1)));
    endtask

    task automatic issue(logic [2:0] cmd, logic [7:0] txb, bit alw);
        send_request(cmd, 1'($urandom_range(1)), 1'($urandom_range(1)), txb, alw);
    endtask

    // low, high, then the falling edge
    task automatic clock_pulse(bit sda);
        repeat ($urandom_range(1, 2)) line_tick(1'b0, sda);
        repeat ($urandom_range(1, 3)) line_tick(1'b1, sda);
        line_tick(1'b0, sda);
    endtask

    task automatic one_pulse(logic [2:0] cmd);
        issue(cmd, 8'($urandom_range(255)), 1'($urandom_range(1)));
        clock_pulse(1'($urandom_range(1)));
    endtask

    task automatic bus_start();
        issue(i2ct_pkg::CMD_COND, 8'($urandom_range(255)), 1'b1);
        repeat ($urandom_range(1, 2)) line_tick(1'b0, 1'b1);
        repeat ($urandom_range(1, 2)) line_tick(1'b1, 1'b1);
        line_tick(1'b1, 1'b0);
        line_tick(1'b0, 1'b0);
    endtask

    task automatic bus_stop(bit alw);
        issue(i2ct_pkg::CMD_COND, 8'($urandom_range(255)), alw);
        repeat ($urandom_range(1, 2)) line_tick(1'b0, 1'b0);
        repeat ($urandom_range(1, 2)) line_tick(1'b1, 1'b0);
        line_tick(1'b1, 1'b1);
    endtask

    // byte from the controller, optionally cut by a bus condition mid byte
    task automatic receive_octet(logic [7:0] b, bit may_break, output bit completed);
        int cut;
        cut       = may_break ? int'($urandom_range(7)) : -1;
        completed = 1'b0;
        issue(i2ct_pkg::CMD_RX, 8'($urandom_range(255)), 1'($urandom_range(1)));
        for (int i = 7; i >= 0; i--) begin
            if (i == cut) begin
                repeat ($urandom_range(1, 2)) line_tick(1'b0, b[i]);
                repeat ($urandom_range(1, 2)) line_tick(1'b1, b[i]);
                line_tick(1'b1, !b[i]);
                return;
            end
            clock_pulse(b[i]);
        end
        completed = 1'b1;
    endtask

    task automatic send_octet(logic [7:0] b);
        issue(i2ct_pkg::CMD_TX, b, 1'($urandom_range(1)));
        repeat (8) clock_pulse(1'($urandom_range(1)));
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // stop patterns until any primitive left over has finished
    task automatic settle_engine();
        int guard;
        guard = 0;
        while (sb.busy() && guard < 20) begin
            line_tick(1'b0, 1'b0);
            line_tick(1'b1, 1'b0);
            line_tick(1'b1, 1'b1);
            guard++;
        end
    endtask

    // start, address, ack and data either way on a match, then stop or repeated start
    task automatic bus_transaction();
        logic [7:0] octet;
        bit         rw;
        bit         got_octet;
        int         count;
        settle_engine();
        bus_start();
        rw    = 1'($urandom_range(1));
        octet = ($urandom_range(99) < 60) ? {sb.own_address, rw} : 8'($urandom_range(255));
        receive_octet(octet, $urandom_range(99) < 8, got_octet);
        if (got_octet && octet[7:1] == sb.own_address) begin
            one_pulse(i2ct_pkg::CMD_ACK);
            count = $urandom_range(1, 3);
            if (octet[0]) begin
                repeat (count) begin
                    send_octet(pick_byte());
                    one_pulse(i2ct_pkg::CMD_PULSE);
                end
            end else begin
                for (int k = 0; k < count && got_octet; k++) begin
                    receive_octet(pick_byte(), $urandom_range(99) < 5, got_octet);
                    if (got_octet)
                        one_pulse(i2ct_pkg::CMD_ACK);
                end
            end
        end
        if ($urandom_range(3) == 0)
            bus_start();
        else
            bus_stop(1'($urandom_range(1)));
    endtask

    // random primitive with random line samples and stray commands
    task automatic garbled_traffic();
        issue(3'($urandom_range(1, 5)), 8'($urandom_range(255)), 1'($urandom_range(1)));
        repeat ($urandom_range(4, 24)) begin
            if ($urandom_range(4) == 0)
                issue(3'($urandom_range(7)), 8'($urandom_range(255)), 1'($urandom_range(1)));
            else
                line_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
        end
    endtask

    task automatic random_requests();
        repeat ($urandom_range(1, 8))
            send_request(3'($urandom_range(7)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                         8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    // stop sending and wait for every due result
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        while (sb.due_results.size() != 0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_own_address(logic [6:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {i2ct_pkg::REG_OWN_ADDRESS, 2'b00};
        pwdata  <= {25'd0, addr};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.own_address = addr;
    endtask

    // stimulus
    initial begin
        logic [6:0] phase_address [5];
        int         pick;
        sb = new();
        steady        <= 1'b0;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_cmd         <= i2ct_pkg::CMD_TICK;
        i_scl_level   <= 1'b1;
        i_sda_level   <= 1'b1;
        i_tx_byte     <= 8'h00;
        i_allow_start <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        engine_items  = 0;
        phase_address[0] = 7'h7F;
        phase_address[1] = 7'h00;
        phase_address[2] = 7'($urandom_range(127));
        phase_address[3] = 7'h55;
        phase_address[4] = 7'h2A;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_own_address(7'h50);

        // idle tick, then a wait that opens with the clock already high
        line_tick(1'b1, 1'b0);
        issue(CMD_UNUSED_6, 8'hFF, 1'b1);
        issue(i2ct_pkg::CMD_COND, 8'h00, 1'b0);
        line_tick(1'b1, 1'b1);
        // commands while busy, start not allowed, then stop
        issue(i2ct_pkg::CMD_COND, 8'h00, 1'b0);
        issue(CMD_UNUSED_7, 8'h00, 1'b0);
        issue(i2ct_pkg::CMD_RX, 8'hFF, 1'b1);
        line_tick(1'b0, 1'b1);
        line_tick(1'b1, 1'b0);
        line_tick(1'b0, 1'b0);
        line_tick(1'b1, 1'b1);
        // start allowed
        issue(i2ct_pkg::CMD_COND, 8'h00, 1'b1);
        line_tick(1'b0, 1'b1);
        line_tick(1'b1, 1'b0);
        // start and stop inside a receive
        issue(i2ct_pkg::CMD_RX, 8'h00, 1'b0);
        line_tick(1'b1, 1'b1);
        line_tick(1'b1, 1'b0);
        issue(i2ct_pkg::CMD_RX, 8'h00, 1'b0);
        line_tick(1'b1, 1'b0);
        line_tick(1'b1, 1'b1);
        // acknowledge and single pulse
        issue(i2ct_pkg::CMD_ACK, 8'h00, 1'b0);
        line_tick(1'b1, 1'b0);
        line_tick(1'b0, 1'b1);
        issue(i2ct_pkg::CMD_PULSE, 8'h00, 1'b0);
        line_tick(1'b1, 1'b1);
        line_tick(1'b0, 1'b0);
        // transmit of all ones, second transmit ignored
        issue(i2ct_pkg::CMD_TX, 8'hFF, 1'b0);
        issue(i2ct_pkg::CMD_TX, 8'h00, 1'b1);
        settle_engine();

        // random phases, one address setting each, one phase without idling
        for (int phase = 0; phase < 5; phase++) begin
            wait_results_drained();
            write_own_address(phase_address[phase]);
            steady <= (phase == 2);
            engine_items = 0;
            while (engine_items < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 70)
                    bus_transaction();
                else if (pick < 85)
                    random_requests();
                else
                    garbled_traffic();
            end
        end

        wait_results_drained();
        repeat (4) @(posedge i_clk);
        if (sb.bad_results == 0 && sb.due_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
